/* sv/pidis_pkg.sv */
// ============================================================================
// pidis_pkg: shared types and constants for the positional PID core
// Holds the sequencer state type, register codes and fixed field widths.
// ============================================================================
package pidis_pkg;

    // Width of a gain or weight operand fed to the serial multiplier
    localparam int GAIN_W = 31;

    // Width of the fixed Q16.16 stream fields
    localparam int FIELD_W = 32;

    // Configuration register codes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_EN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_BEGIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_FULL  = 3'd7;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL1,
        ST_WAIT1,
        ST_MUL2,
        ST_WAIT2,
        ST_SUM
    } pidis_state_t;

endpackage

/* sv/pidis_mul.sv */
// ============================================================================
// pidis_mul: bit-serial signed-by-unsigned fractional multiplier
// Shift-add over one gain bit per cycle, then (|v|*g) >> FB saturated.
// ============================================================================
module pidis_mul
    import pidis_pkg::*;
#(
    parameter int DW = 32,
    parameter int FB = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] v,
    input  logic [GAIN_W-1:0]    g,
    output logic                 done,
    output logic signed [DW-1:0] res
);

    localparam int PW    = DW + GAIN_W;
    localparam int QW    = PW - FB;
    localparam int CNT_W = $clog2(GAIN_W + 1);
    localparam logic [QW-1:0] LIM = QW'(1) << (DW - 1);
    localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [DW-1:0]     m_reg;
    logic [GAIN_W-1:0] g_reg;
    logic [DW-1:0]     hi_reg;
    logic [GAIN_W-1:0] lo_reg;
    logic [DW-1:0]     res_reg;
    logic              done_reg;

    logic [DW:0]       step_sum;
    logic [PW-1:0]     prod;
    logic [QW-1:0]     quo;
    logic [DW-1:0]     mag;
    logic [DW-1:0]     res_next;

    // One partial product per cycle
    assign step_sum = {1'b0, hi_reg} + (g_reg[0] ? {1'b0, m_reg} : '0);

    // Scale, saturate and restore the sign
    always_comb
    begin
        prod = {hi_reg, lo_reg};
        quo  = prod[PW-1:FB];
        mag  = (quo > LIM) ? LIM[DW-1:0] : quo[DW-1:0];
        if (neg_reg)
        begin
            res_next = ~mag + 1'b1;
        end
        else
        begin
            res_next = mag[DW-1] ? POS_MAX : mag;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(GAIN_W);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= v[DW-1];
            m_reg   <= v[DW-1] ? (~v + 1'b1) : v;
            g_reg   <= g;
            hi_reg  <= '0;
            lo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                hi_reg <= step_sum[DW:1];
                lo_reg <= {step_sum[0], lo_reg[GAIN_W-1:1]};
                g_reg  <= g_reg >> 1;
            end
            else
            begin
                res_reg <= res_next;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* sv/pidis_div.sv */
// ============================================================================
// pidis_div: restoring divider for the separation weight
// Computes (num << FB) / den one quotient bit per cycle, num <= den.
// ============================================================================
module pidis_div
    import pidis_pkg::*;
#(
    parameter int FB = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [GAIN_W-1:0] num,
    input  logic [GAIN_W-1:0] den,
    output logic [FB:0]       quo
);

    localparam int CNT_W = $clog2(FB + 2);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [GAIN_W:0]   rem_reg;
    logic [GAIN_W-1:0] den_reg;
    logic [FB:0]       quo_reg;

    logic              fits;
    logic [GAIN_W:0]   rem_sub;

    assign fits    = rem_reg >= {1'b0, den_reg};
    assign rem_sub = fits ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(FB + 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Subtract, shift in a quotient bit, double the remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[FB-1:0], fits};
            rem_reg <= {rem_sub[GAIN_W-1:0], 1'b0};
        end
    end

    assign quo = quo_reg;

endmodule

/* sv/position_pid_integral_separation_core.sv */
// ============================================================================
// position_pid_integral_separation_core: positional PID with integral separation
// Q16.16 error, clamped integral and derivative terms on bit-serial multipliers.
// ============================================================================
//  channel  | signals                         | content
//  s_axis   | tvalid tready tdata[63:0]       | target, measured
//  m_axis   | tvalid tready tdata[31:0]       | drive
//  cfg      | valid ready index[2:0] data[31:0]| register writes, always ready
//
//  An item runs through prep, two multiplier passes (start, 31 shift-add
//  steps, then the result and the done strobe; P, D and gain*integral in
//  parallel, then times the weight k) and the final sum; the next item is
//  accepted only in the idle state after that. The weight divider runs
//  beside the first pass. Reset clears the registers, the integral and the
//  previous error. A finished drive waits in the output register; the
//  next item is taken meanwhile and stalls only at its final sum if the drive
//  is still untaken.
// ============================================================================
module position_pid_integral_separation_core
    import pidis_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*FIELD_W-1:0] s_axis_tdata,   // target, measured
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [FIELD_W-1:0]   m_axis_tdata,   // drive
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    localparam int DW = DATA_WIDTH;
    localparam int AW = (DW > FIELD_W) ? DW : FIELD_W;
    localparam int CW = AW + 3;
    localparam logic signed [CW-1:0] DMAX = {{(CW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [CW-1:0] DMIN = ~DMAX;
    localparam logic signed [CW-1:0] FMAX = {{(CW-FIELD_W+1){1'b0}}, {(FIELD_W-1){1'b1}}};
    localparam logic signed [CW-1:0] FMIN = ~FMAX;
    localparam logic [FRAC_BITS:0]   K_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Saturate to signed DW bits
    function automatic logic signed [CW-1:0] sat_dw(input logic signed [CW-1:0] x);
        logic signed [CW-1:0] r;
        r = x;
        if (x > DMAX)
        begin
            r = DMAX;
        end
        else if (x < DMIN)
        begin
            r = DMIN;
        end
        return r;
    endfunction

    // Clamp to +/- a 31-bit limit
    function automatic logic signed [CW-1:0] clamp_sym(input logic signed [CW-1:0] x,
                                                       input logic [GAIN_W-1:0] lim);
        logic signed [CW-1:0] l;
        logic signed [CW-1:0] r;
        l = $signed(CW'(lim));
        r = x;
        if (x < -l)
        begin
            r = -l;
        end
        else if (x > l)
        begin
            r = l;
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] ext(input logic signed [DW-1:0] x);
        return {{(CW-DW){x[DW-1]}}, x};
    endfunction

    pidis_state_t state_reg, state_next;

    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [GAIN_W-1:0] int_lim_reg, out_lim_reg, sep_begin_reg, sep_full_reg;
    logic              sep_en_reg;

    logic signed [DW-1:0] err_reg, sum_reg, last_reg, dv_reg;
    logic                 kz_reg, k1_reg;
    logic [FIELD_W-1:0]   out_data_reg;
    logic                 out_valid_reg;

    logic                 in_xfer;
    logic                 out_free;
    logic                 start1, start2, div_start;
    logic signed [CW-1:0] diff_in, aerr, es_next, sum_w, drive_w;
    logic                 over_begin;
    logic [GAIN_W-1:0]    div_num, div_den;
    logic [FRAC_BITS:0]   div_q, k_sel;
    logic                 p_done, i_done, d_done;
    logic signed [DW-1:0] p_res, i_res, d_res, i_v;
    logic [GAIN_W-1:0]    i_g;

    assign cfg_ready = 1'b1;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            int_lim_reg   <= '0;
            out_lim_reg   <= '0;
            sep_en_reg    <= 1'b0;
            sep_begin_reg <= '0;
            sep_full_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN_P:    gain_p_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:    gain_i_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:    gain_d_reg    <= cfg_data[GAIN_W-1:0];
                REG_INT_LIM:   int_lim_reg   <= cfg_data[GAIN_W-1:0];
                REG_OUT_LIM:   out_lim_reg   <= cfg_data[GAIN_W-1:0];
                REG_SEP_EN:    sep_en_reg    <= cfg_data[0];
                REG_SEP_BEGIN: sep_begin_reg <= cfg_data[GAIN_W-1:0];
                REG_SEP_FULL:  sep_full_reg  <= cfg_data[GAIN_W-1:0];
                default:       sep_en_reg    <= sep_en_reg;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_xfer) state_next = ST_PREP;
            ST_PREP:  state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_WAIT1;
            ST_WAIT1: if (i_done && p_done && d_done) state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_WAIT2;
            ST_WAIT2: if (i_done) state_next = ST_SUM;
            ST_SUM:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        start1        = 1'b0;
        start2        = 1'b0;
        div_start     = 1'b0;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_PREP: div_start     = 1'b1;
            ST_MUL1: start1        = 1'b1;
            ST_MUL2: start2        = 1'b1;
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Error, separation decision and integral update
    always_comb
    begin
        diff_in = $signed({{(CW-FIELD_W){s_axis_tdata[FIELD_W-1]}},
                           s_axis_tdata[FIELD_W-1:0]})
                - $signed({{(CW-FIELD_W){s_axis_tdata[2*FIELD_W-1]}},
                           s_axis_tdata[2*FIELD_W-1:FIELD_W]});
        aerr       = err_reg[DW-1] ? -ext(err_reg) : ext(err_reg);
        over_begin = sep_en_reg && (aerr > $signed(CW'(sep_begin_reg)));
        es_next    = over_begin ? ext(sum_reg) : sat_dw(ext(sum_reg) + ext(err_reg));
        es_next    = clamp_sym(es_next, int_lim_reg);
        div_num    = sep_begin_reg - aerr[GAIN_W-1:0];
        div_den    = sep_begin_reg - sep_full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            last_reg <= '0;
        end
        else if (state_reg == ST_PREP)
        begin
            sum_reg  <= DW'(es_next);
            last_reg <= err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            err_reg <= DW'(sat_dw(diff_in));
        end
        if (state_reg == ST_PREP)
        begin
            dv_reg <= DW'(sat_dw(ext(err_reg) - ext(last_reg)));
            kz_reg <= over_begin;
            k1_reg <= !sep_en_reg || (aerr < $signed(CW'(sep_full_reg)))
                   || (sep_begin_reg == sep_full_reg);
        end
    end

    pidis_div #(.FB(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_q)
    );

    // Integral weight
    always_comb
    begin
        if (kz_reg)
        begin
            k_sel = '0;
        end
        else if (k1_reg)
        begin
            k_sel = K_ONE;
        end
        else
        begin
            k_sel = div_q;
        end
    end

    pidis_mul #(.DW(DW), .FB(FRAC_BITS)) u_mul_p (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start1),
        .v     (err_reg),
        .g     (gain_p_reg),
        .done  (p_done),
        .res   (p_res)
    );

    pidis_mul #(.DW(DW), .FB(FRAC_BITS)) u_mul_d (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start1),
        .v     (dv_reg),
        .g     (gain_d_reg),
        .done  (d_done),
        .res   (d_res)
    );

    // Integral path runs twice: gain, then weight
    assign i_v = start2 ? i_res : sum_reg;
    assign i_g = start2 ? GAIN_W'(k_sel) : gain_i_reg;

    pidis_mul #(.DW(DW), .FB(FRAC_BITS)) u_mul_i (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start1 || start2),
        .v     (i_v),
        .g     (i_g),
        .done  (i_done),
        .res   (i_res)
    );

    // Final sum, output clamp and field saturation
    always_comb
    begin
        sum_w   = sat_dw(ext(p_res) + ext(i_res) + ext(d_res));
        drive_w = clamp_sym(sum_w, out_lim_reg);
        if (drive_w > FMAX)
        begin
            drive_w = FMAX;
        end
        else if (drive_w < FMIN)
        begin
            drive_w = FMIN;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_SUM && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SUM && out_free)
        begin
            out_data_reg <= drive_w[FIELD_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* tb/sv/tb_position_pid_integral_separation_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_position_pid_integral_separation_core: self-checking bench for the PID core
// Drives set point / measurement transfers under several register settings,
// predicts each drive value with a cycle-free PID model and compares results.
// ============================================================================
module tb_position_pid_integral_separation_core;
    import pidis_pkg::*;

    localparam int  DW        = 32;
    localparam int  FB        = 16;
    localparam int  WDOG_MAX  = 20000;
    localparam int  DRAIN_CYC = 200;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [2*FIELD_W-1:0] s_axis_tdata;   // target, measured
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [FIELD_W-1:0]   m_axis_tdata;   // drive
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_data;

    // Predictor copy of registers and loop state
    longint unsigned kp, ki, kd, int_lim, out_lim, sep_en, sep_begin, sep_full;
    longint          err_sum, prev_err;

    logic [FIELD_W-1:0] drive_q[$];
    int                 fail_count;
    int                 idle_cycles;
    int                 stall_mode;

    position_pid_integral_separation_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clamp_lim(longint x, longint unsigned lim);
        longint l;
        l = longint'(lim);
        if (x < -l)
            return -l;
        if (x > l)
            return l;
        return x;
    endfunction

    // Q16.16 product truncated toward zero, saturated
    function automatic longint gain_mul(longint v, longint unsigned g);
        logic [127:0]    prod;
        longint unsigned mag;
        longint unsigned r;
        mag  = (v < 0) ? longint'(-v) : longint'(v);
        prod = 128'(mag) * 128'(g);
        prod = prod >> FB;
        r    = (prod > 128'(64'd2147483648)) ? 64'd2147483648 : prod[63:0];
        return sat32((v < 0) ? -longint'(r) : longint'(r));
    endfunction

    // Compute the drive for one set point / measurement pair
    function automatic logic [FIELD_W-1:0] pid_drive(logic [31:0] tgt, logic [31:0] meas);
        longint          err, p, i, d, total;
        longint unsigned aerr, wgt;
        bit              accum;
        wgt   = 64'd1 << FB;
        accum = 1'b1;
        err   = sat32(longint'($signed(tgt)) - longint'($signed(meas)));
        aerr  = (err < 0) ? longint'(-err) : longint'(err);
        if (sep_en != 0)
        begin
            if (aerr > sep_begin)
            begin
                wgt   = 0;
                accum = 1'b0;
            end
            else if (aerr < sep_full || sep_begin == sep_full)
                wgt = 64'd1 << FB;
            else
                wgt = ((sep_begin - aerr) << FB) / (sep_begin - sep_full);
        end
        if (accum)
            err_sum = sat32(err_sum + err);
        err_sum  = clamp_lim(err_sum, int_lim);
        p        = gain_mul(err, kp);
        i        = gain_mul(gain_mul(err_sum, ki), wgt);
        d        = gain_mul(sat32(err - prev_err), kd);
        total    = clamp_lim(sat32(p + i + d), out_lim);
        prev_err = err;
        return total[31:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Check each drive transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (drive_q.size() == 0)
                report_mismatch($sformatf("unexpected drive %h", m_axis_tdata));
            else
            begin
                logic [FIELD_W-1:0] want;
                want = drive_q.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch($sformatf("drive %h expected %h", m_axis_tdata, want));
            end
        end
    end

    // Receiver stall pattern; mode 0 never stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_mode == 0)
            m_axis_tready <= 1'b1;
        else if (stall_mode == 1)
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        else
            m_axis_tready <= ($urandom_range(0, 9) == 0);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GAIN_P:    kp        = val & 32'h7FFF_FFFF;
            REG_GAIN_I:    ki        = val & 32'h7FFF_FFFF;
            REG_GAIN_D:    kd        = val & 32'h7FFF_FFFF;
            REG_INT_LIM:   int_lim   = val & 32'h7FFF_FFFF;
            REG_OUT_LIM:   out_lim   = val & 32'h7FFF_FFFF;
            REG_SEP_EN:    sep_en    = val & 1;
            REG_SEP_BEGIN: sep_begin = val & 32'h7FFF_FFFF;
            REG_SEP_FULL:  sep_full  = val & 32'h7FFF_FFFF;
            default: ;
        endcase
        // Hold valid low between writes
        @(posedge clk);
    endtask

    task automatic set_all(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                           logic [31:0] ilim, logic [31:0] olim, logic [31:0] en,
                           logic [31:0] sb, logic [31:0] sf);
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_INT_LIM, ilim);
        write_reg(REG_OUT_LIM, olim);
        write_reg(REG_SEP_EN, en);
        write_reg(REG_SEP_BEGIN, sb);
        write_reg(REG_SEP_FULL, sf);
    endtask

    // Wait out all pending drives plus the core's own latency
    task automatic drain();
        int n;
        n = 0;
        while (drive_q.size() != 0 && n < 400000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // Send one pair; valid stays high across back-to-back pairs
    task automatic send_pair(logic [31:0] tgt, logic [31:0] meas, bit hold);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {meas, tgt};
        do @(posedge clk); while (!s_axis_tready);
        drive_q.push_back(pid_drive(tgt, meas));
        if (!hold)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_val(int shape);
        case (shape)
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 2 ** 20)) - (2 ** 19));
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2 ** 18)) - (2 ** 17));
        endcase
    endfunction

    // Bursts of pairs with random gaps in between
    task automatic random_pairs(int count);
        int left, burst, shape;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 8);
            if (burst > left)
                burst = left;
            shape = $urandom_range(0, 3);
            for (int b = 0; b < burst; b++)
                send_pair(rand_val(shape), rand_val(shape), b != burst - 1);
            left -= burst;
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    task automatic test_extremes();
        set_all(32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 0, 0, 0);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        send_pair(32'h0001_0000, 32'hFFFF_0000, 1'b0);
        drain();
        // Max gains; the extreme errors saturate the products
        set_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 0, 0, 0);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_pair(32'h0000_0001, 32'h0000_0000, 1'b0);
        drain();
    endtask

    task automatic test_zero_limits();
        set_all(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0, 0);
        send_pair(32'h0100_0000, 32'h0000_0000, 1'b0);
        send_pair(32'hFF00_0000, 32'h0000_0000, 1'b0);
        drain();
        // Small integral limit, small drive limit, with high ignored bits
        set_all(32'h8001_0000, 32'h0001_0000, 0, 32'h0003_0000, 32'h0005_0000, 32'hFFFF_FFFE,
                0, 0);
        for (int n = 0; n < 4; n++)
            send_pair(32'h0002_0000, 32'h0000_0000, 1'b0);
        drain();
    endtask

    task automatic test_separation();
        // Linear weight region and suppression above begin
        set_all(32'h0000_8000, 32'h0001_0000, 32'h0000_4000, 32'h0100_0000,
                32'h7FFF_FFFF, 1, 32'h0004_0000, 32'h0001_0000);
        send_pair(32'h0000_8000, 0, 1'b0);
        send_pair(32'h0002_0000, 0, 1'b0);
        send_pair(32'h0004_0000, 0, 1'b0);
        send_pair(32'h0004_0001, 0, 1'b0);
        send_pair(32'hFFFD_0000, 0, 1'b0);
        drain();
        // Equal thresholds
        write_reg(REG_SEP_FULL, 32'h0004_0000);
        send_pair(32'h0004_0000, 0, 1'b0);
        send_pair(32'hFFFC_0000, 0, 1'b0);
        drain();
        // Full above begin
        write_reg(REG_SEP_FULL, 32'h7FFF_FFFF);
        send_pair(32'h0003_0000, 0, 1'b0);
        send_pair(32'h0005_0000, 0, 1'b0);
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++)
        begin
            stall_mode = ph % 3;
            set_all($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0001_0000),
                    $urandom_range(0, 32'h0002_0000),
                    (ph == 5) ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0100_0000),
                    (ph == 4) ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0800_0000),
                    ph % 2, $urandom_range(32'h0002_0000, 32'h0008_0000),
                    $urandom_range(0, 32'h0003_0000));
            random_pairs(310);
            drain();
        end
        // Unknown-free raw random values in every register, separation enabled
        stall_mode = 1;
        set_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 1,
                $urandom(), $urandom());
        random_pairs(40);
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        fail_count    = 0;
        idle_cycles   = 0;
        stall_mode    = 0;
        kp = 0; ki = 0; kd = 0; int_lim = 0; out_lim = 0;
        sep_en = 0; sep_begin = 0; sep_full = 0;
        err_sum = 0; prev_err = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Reset registers give zero drive
        send_pair(32'h1234_5678, 32'h8765_4321, 1'b0);
        drain();
        test_extremes();
        stall_mode = 2;
        test_zero_limits();
        test_separation();
        test_random();
        if (fail_count == 0 && drive_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
